// ----- src/p2c_pkg.sv -----
// ----------------------------------------------------------------------------
// p2c_pkg: shared types and constants for the planar-to-chunky pixel reader
// Item payloads, controller/datapath command and status, store geometry
// and the fixed eight-entry palette.
// ----------------------------------------------------------------------------
package p2c_pkg;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int MAX_PLANES    = 8;
    localparam int MAX_ROW_BYTES = ((MAX_WIDTH + 15) / 16) * 2;
    localparam int STORE_SIZE    = MAX_PLANES * MAX_ROW_BYTES * MAX_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PLANE_COUNT  = 2'd2;

    // Item kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] plane_byte;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [2:0]  colour_index;
        logic        out_of_range;
    } out_item_t;

    typedef struct packed {
        logic accept_load;
        logic accept_read;
        logic issue_read;
        logic gather;
        logic finish;
    } p2c_cmd_t;

    typedef struct packed {
        logic settling;
        logic oor;
        logic last_plane;
        logic out_busy;
    } p2c_status_t;

    function automatic logic [23:0] palette_lookup(input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0:    rgb = 24'hAAAAAA;
            3'd1:    rgb = 24'h000000;
            3'd2:    rgb = 24'hFFFFFF;
            3'd3:    rgb = 24'h6688BB;
            3'd4:    rgb = 24'h999999;
            3'd5:    rgb = 24'hBBBBBB;
            3'd6:    rgb = 24'hBBAA99;
            3'd7:    rgb = 24'hFFBBAA;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

// ----- src/p2c_ctrl.sv -----
// ----------------------------------------------------------------------------
// p2c_ctrl: sequencer for the planar-to-chunky pixel reader
// Accepts requests, steps the datapath through one store read per gathered plane
// and hands the finished pixel to the output register.
// ----------------------------------------------------------------------------
module p2c_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  p2c_pkg::p2c_status_t status,
    output p2c_pkg::p2c_cmd_t    cmd
);
    import p2c_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_GATHER = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && !status.settling;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept_load = accept && (s_action == ACT_LOAD);
        cmd.accept_read = accept && (s_action == ACT_READ);
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // An out-of-range pixel skips the store entirely.
                if (status.oor) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.issue_read = 1'b1;
                    state_next     = ST_GATHER;
                end
            end
            ST_GATHER: begin
                cmd.gather = 1'b1;
                state_next = status.last_plane ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_read |=> cmd.gather)
        else $error("p2c_ctrl: store read not followed by a gather");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_ready || status.settling)
        else $error("p2c_ctrl: controller did not return to idle after finish");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept_read || cmd.accept_load) |-> !status.settling)
        else $error("p2c_ctrl: request accepted while geometry settles");

endmodule

// ----- src/p2c_datapath.sv -----
// ----------------------------------------------------------------------------
// p2c_datapath: store, geometry and pixel assembly
// Holds the configuration, the derived plane geometry, the byte store with
// its load pointer, the per-pixel address walker and the output register.
// ----------------------------------------------------------------------------
module p2c_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  p2c_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output p2c_pkg::out_item_t   m_data,
    input  p2c_pkg::p2c_cmd_t    cmd,
    output p2c_pkg::p2c_status_t status
);
    import p2c_pkg::*;

    // Configuration registers.
    logic [7:0] width_reg, height_reg;
    logic [3:0] planes_reg;

    // Saturated geometry.
    logic [7:0] w_eff, h_eff;
    logic [3:0] np_eff;
    logic [3:0] row_words;
    logic [4:0] rb;
    logic [1:0] nr;

    logic [7:0]  w_eff_reg, h_eff_reg;
    logic [3:0]  np_eff_reg;
    logic [4:0]  rb_reg;
    logic [1:0]  nr_reg;
    logic [11:0] ps_reg;
    logic [14:0] total_reg;
    logic [1:0]  settle_reg;

    // Store and load pointer.
    logic [7:0]        store_mem [STORE_SIZE];
    logic [ADDR_W-1:0] ptr_reg, ptr_start;
    logic [ADDR_W:0]   ptr_inc;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        rd_data_reg;

    // Pixel walker.
    logic [ADDR_W-1:0] base_reg, off_reg;
    logic [2:0]        bitsel_reg;
    logic [1:0]        plane_idx_reg;
    logic [2:0]        colour_reg;
    logic              oor_reg;
    logic              pix_bit;
    logic [10:0]       pixel_offset;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_comb begin
        if (width_reg == 8'd0) begin
            w_eff = 8'd1;
        end else if (width_reg > 8'(MAX_WIDTH)) begin
            w_eff = 8'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == 8'd0) begin
            h_eff = 8'd1;
        end else if (height_reg > 8'(MAX_HEIGHT)) begin
            h_eff = 8'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if (planes_reg == 4'd0) begin
            np_eff = 4'd1;
        end else if (planes_reg > 4'(MAX_PLANES)) begin
            np_eff = 4'(MAX_PLANES);
        end else begin
            np_eff = planes_reg;
        end
        row_words = 4'((9'(w_eff) + 9'd15) >> 4);
        rb        = {row_words, 1'b0};
        // Only the low three colour bits survive, so at most three planes matter.
        nr        = (np_eff >= 4'd3) ? 2'd3 : np_eff[1:0];
    end

    // Derived geometry is registered; total_reg follows ps_reg and np_eff_reg.
    always_ff @(posedge aclk) begin
        w_eff_reg  <= w_eff;
        h_eff_reg  <= h_eff;
        np_eff_reg <= np_eff;
        rb_reg     <= rb;
        nr_reg     <= nr;
        ps_reg     <= 12'(rb) * 12'(h_eff);
        total_reg  <= 15'(np_eff_reg) * 15'(ps_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd32;
            height_reg <= 8'd32;
            planes_reg <= 4'd2;
            settle_reg <= 2'd2;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_PLANE_COUNT:  planes_reg <= cfg_data[3:0];
                    default: ;
                endcase
                settle_reg <= 2'd2;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // A pointer left beyond the image by a geometry change restarts at zero.
    assign ptr_start = ({1'b0, ptr_reg} >= total_reg) ? '0 : ptr_reg;
    assign ptr_inc   = {1'b0, ptr_start} + 15'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.accept_load) begin
            ptr_reg <= (ptr_inc >= total_reg) ? '0 : ptr_inc[ADDR_W-1:0];
        end
    end

    assign mem_addr = cmd.accept_load ? ptr_start : (base_reg + off_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept_load) begin
            store_mem[mem_addr] <= s_data.plane_byte;
        end
        if (cmd.issue_read) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    assign pixel_offset = 11'(s_data.pixel_y) * 11'(rb_reg) + 11'(s_data.pixel_x[6:3]);
    assign pix_bit      = rd_data_reg[3'd7 - bitsel_reg];

    always_ff @(posedge aclk) begin
        if (cmd.accept_read) begin
            base_reg   <= ADDR_W'(pixel_offset);
            off_reg    <= '0;
            bitsel_reg <= s_data.pixel_x[2:0];
            oor_reg    <= ({1'b0, s_data.pixel_x} >= w_eff_reg)
                       || ({1'b0, s_data.pixel_y} >= h_eff_reg);
        end else if (cmd.gather) begin
            off_reg <= off_reg + ADDR_W'(ps_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_idx_reg <= '0;
            colour_reg    <= '0;
        end else if (cmd.accept_read) begin
            plane_idx_reg <= '0;
            colour_reg    <= '0;
        end else if (cmd.gather) begin
            plane_idx_reg <= plane_idx_reg + 2'd1;
            colour_reg    <= colour_reg | (3'(pix_bit) << plane_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (oor_reg) begin
                m_data_reg <= '{pixel_rgb: 24'd0, colour_index: 3'd0, out_of_range: 1'b1};
            end else begin
                m_data_reg <= '{pixel_rgb: palette_lookup(colour_reg),
                                colour_index: colour_reg, out_of_range: 1'b0};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.settling   = (settle_reg != 2'd0);
    assign status.oor        = oor_reg;
    assign status.last_plane = (plane_idx_reg == (nr_reg - 2'd1));
    assign status.out_busy   = m_valid_reg && !m_ready;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept_load |=> ({1'b0, ptr_reg} < total_reg))
        else $error("p2c_datapath: load pointer past the end of the image");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("p2c_datapath: finished pixel not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gather |-> !oor_reg && (plane_idx_reg < nr_reg))
        else $error("p2c_datapath: plane gathered for an invalid pixel or plane");

endmodule

// ----- src/planar_to_chunky_palette.sv -----
// ----------------------------------------------------------------------------
// planar_to_chunky_palette: bitplane image store with chunky pixel readout
// Usage:
//   s_valid/s_ready/s_data carries requests. A load request (action 0)
//   writes plane_byte at the load pointer and returns nothing; the
//   pointer wraps after plane_count planes of the current geometry.
//   A read request (action 1) returns one m_data item: palette colour,
//   colour index and the out-of-range flag.
//   A read gathers each plane by a registered read of the single-port
//   byte store and then the bit pick, at most 3 planes since only the low
//   three index bits are kept, and then registers the result; an
//   out-of-range pixel skips the store. One read is in flight at a time;
//   the next request is taken as soon as the result is registered.
//   cfg_valid/cfg_ready writes image_width (0), image_height (1) and
//   plane_count (2); cfg_ready is always high, and s_ready drops after a
//   write while the plane geometry is recomputed.
//   Reset restores the default 32x32, two-plane geometry and a zero load
//   pointer; store contents are undefined until loaded. A stalled m_ready
//   holds the result and, once the next result is ready, holds the reader.
// ----------------------------------------------------------------------------
module planar_to_chunky_palette (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  p2c_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output p2c_pkg::out_item_t   m_data
);
    import p2c_pkg::*;

    p2c_cmd_t    cmd;
    p2c_status_t status;

    assign cfg_ready = 1'b1;

    p2c_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .status   (status),
        .cmd      (cmd)
    );

    p2c_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for planar_to_chunky_palette
// Loads bitplane images under a series of geometries (small, the
// saturated extremes and random ones), reads pixels inside and outside the
// image, and checks every returned pixel against a local planar store that
// mirrors the load pointer, the plane layout and the eight-colour palette.
// ----------------------------------------------------------------------------
module tb;
    import p2c_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_AFTER    = 20;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned STALL_LIMIT   = 3000;

    // Index 0 is the rightmost entry.
    localparam logic [7:0][23:0] PALETTE_RGB = {
        24'hFFBBAA, 24'hBBAA99, 24'hBBBBBB, 24'h999999,
        24'h6688BB, 24'hFFFFFF, 24'h000000, 24'hAAAAAA
    };

    // Hand-made three-plane 8x2 image, store order. Row 0 holds all colours.
    localparam logic [11:0][7:0] TEST_PLANES = {
        8'hFF, 8'h33, 8'h00, 8'hAA,
        8'hFF, 8'h0F, 8'h00, 8'hCC,
        8'hFF, 8'h55, 8'h00, 8'hF0
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [7:0] cfg_data  = 8'd0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;

    planar_to_chunky_palette uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Geometry registers as last written, shared by the planner and predictor.
    logic [7:0] geo_width  = 8'd32;
    logic [7:0] geo_height = 8'd32;
    logic [3:0] geo_planes = 4'd2;

    // Predictor state, advanced on accepted requests.
    bit [7:0]    img_store [STORE_SIZE];
    int unsigned load_ptr = 0;

    // Planner state, advanced as requests are queued.
    bit          plan_written [STORE_SIZE];
    int unsigned plan_ptr = 0;

    in_item_t    req_q[$];
    out_item_t   pixel_exp[$];
    out_item_t   head_pixel;

    bit          calm = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned pixels_seen = 0;
    int unsigned stall_cycles = 0;

    int unsigned n_loads = 0;
    int unsigned n_reads = 0;
    int unsigned n_outside = 0;
    int unsigned n_reg_writes = 0;
    int unsigned n_bad = 0;
    int unsigned n_unexpected = 0;
    logic [7:0]  colours_seen = 8'd0;

    function automatic int unsigned clamp_to(input int unsigned v, lo, hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned cols();
        return clamp_to(geo_width, 1, MAX_WIDTH);
    endfunction

    function automatic int unsigned rows();
        return clamp_to(geo_height, 1, MAX_HEIGHT);
    endfunction

    function automatic int unsigned planes();
        return clamp_to(geo_planes, 1, MAX_PLANES);
    endfunction

    function automatic int unsigned row_stride();
        return ((cols() + 15) / 16) * 2;
    endfunction

    function automatic int unsigned image_bytes();
        return planes() * row_stride() * rows();
    endfunction

    function automatic int unsigned pixel_addr(input int unsigned p, x, y);
        return p * row_stride() * rows() + y * row_stride() + x / 8;
    endfunction

    // A pointer at or past the end of the current image goes back to zero.
    function automatic int unsigned wrap_ptr(input int unsigned p);
        return (p >= image_bytes()) ? 0 : p;
    endfunction

    // Only the planes that feed the three index bits are fetched.
    function automatic bit read_is_safe(input int unsigned x, y);
        int unsigned p;
        if (x >= cols() || y >= rows()) return 1'b1;
        for (p = 0; p < planes() && p < 3; p++)
            if (!plan_written[pixel_addr(p, x, y)]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_load(input logic [7:0] value);
        in_item_t    item;
        int unsigned slot;
        item.action     = ACT_LOAD;
        item.plane_byte = value;
        item.pixel_x    = 7'($urandom_range(0, 127));
        item.pixel_y    = 7'($urandom_range(0, 127));
        req_q.push_back(item);
        slot = wrap_ptr(plan_ptr);
        plan_written[slot] = 1'b1;
        plan_ptr = wrap_ptr(slot + 1);
    endtask

    task automatic queue_read(input int unsigned x, y);
        in_item_t item;
        item.action     = ACT_READ;
        item.plane_byte = 8'($urandom_range(0, 255));
        item.pixel_x    = 7'(x);
        item.pixel_y    = 7'(y);
        req_q.push_back(item);
    endtask

    task automatic queue_mixed();
        int unsigned pick, x, y, tries;
        pick = $urandom_range(0, 99);
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 127);
        if (pick < 35) begin
            queue_load(8'($urandom_range(0, 255)));
        end else begin
            if (pick < 50 && (cols() < 128 || rows() < 128)) begin
                if (cols() < 128 && (rows() == 128 || $urandom_range(0, 1) == 1)) begin
                    x = $urandom_range(cols(), 127);
                end else begin
                    y = $urandom_range(rows(), 127);
                end
            end else if (pick >= 60) begin
                x = $urandom_range(0, cols() - 1);
                y = $urandom_range(0, rows() - 1);
                for (tries = 1; tries < 8 && !read_is_safe(x, y); tries++) begin
                    x = $urandom_range(0, cols() - 1);
                    y = $urandom_range(0, rows() - 1);
                end
            end
            // A pixel whose planes are not loaded yet becomes a load instead.
            if (read_is_safe(x, y)) queue_read(x, y);
            else queue_load(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic predict_item(input in_item_t it);
        out_item_t   want;
        int unsigned slot, p, idx;
        bit [7:0]    plane_bits;
        if (it.action == ACT_LOAD) begin
            slot = wrap_ptr(load_ptr);
            img_store[slot] = it.plane_byte;
            load_ptr = wrap_ptr(slot + 1);
            n_loads++;
        end else begin
            want = '0;
            n_reads++;
            if (it.pixel_x >= cols() || it.pixel_y >= rows()) begin
                want.out_of_range = 1'b1;
                n_outside++;
            end else begin
                idx = 0;
                for (p = 0; p < planes(); p++) begin
                    plane_bits = img_store[pixel_addr(p, it.pixel_x, it.pixel_y)];
                    if (plane_bits[7 - it.pixel_x[2:0]]) idx |= 1 << p;
                end
                idx &= 7;
                want.colour_index = 3'(idx);
                want.pixel_rgb    = PALETTE_RGB[idx];
                colours_seen[idx] = 1'b1;
            end
            pixel_exp.push_back(want);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_reg_writes++;
        case (idx)
            REG_IMAGE_WIDTH:  geo_width  = value;
            REG_IMAGE_HEIGHT: geo_height = value;
            REG_PLANE_COUNT:  geo_planes = value[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (req_q.size() != 0 || s_valid || pixel_exp.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] w, h, input logic [3:0] np,
                             input int unsigned fill_cap, mixed, input bit quiet);
        int unsigned n;
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_PLANE_COUNT, {4'd0, np});
        @(negedge aclk);
        calm = quiet;
        n = (image_bytes() < fill_cap) ? image_bytes() : fill_cap;
        repeat (n) queue_load(8'($urandom_range(0, 255)));
        repeat (mixed) queue_mixed();
        wait_idle();
    endtask

    // Request driver; the predictor runs on every accepted request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_item(s_data);
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    s_valid <= 1'b1;
                    s_data  <= req_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, with one long hold-off to fill the block.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && pixels_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // Pixel monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            pixels_seen <= pixels_seen + 1;
            if (pixel_exp.size() == 0) begin
                n_unexpected++;
                if (n_bad + n_unexpected <= 10)
                    $display("%0t: unexpected pixel rgb=%06h idx=%0d oor=%0b", $realtime,
                             m_data.pixel_rgb, m_data.colour_index, m_data.out_of_range);
            end else begin
                head_pixel = pixel_exp.pop_front();
                if (m_data.pixel_rgb !== head_pixel.pixel_rgb ||
                    m_data.colour_index !== head_pixel.colour_index ||
                    m_data.out_of_range !== head_pixel.out_of_range) begin
                    n_bad++;
                    if (n_bad + n_unexpected <= 10) begin
                        $display("%0t: pixel mismatch: expected rgb=%06h idx=%0d oor=%0b",
                                 $realtime, head_pixel.pixel_rgb, head_pixel.colour_index,
                                 head_pixel.out_of_range);
                        $display("    got rgb=%06h idx=%0d oor=%0b",
                                 m_data.pixel_rgb, m_data.colour_index,
                                 m_data.out_of_range);
                    end
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned i;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: an 8x2 three-plane image, one wrapping load, every colour,
        // the far corner and reads just past each edge.
        write_reg(REG_IMAGE_WIDTH, 8'd8);
        write_reg(REG_IMAGE_HEIGHT, 8'd2);
        write_reg(REG_PLANE_COUNT, 8'd3);
        @(negedge aclk);
        for (i = 0; i < 12; i++) queue_load(TEST_PLANES[i]);
        queue_load(8'hF0);
        for (i = 0; i < 8; i++) queue_read(i, 0);
        queue_read(7, 1);
        queue_read(8, 0);
        queue_read(0, 2);
        queue_read(127, 127);
        wait_idle();

        run_phase(8'd16, 8'd4, 4'd3, 24, 50, 1'b0);
        run_phase(8'd0, 8'd0, 4'd0, 2, 50, 1'b0);
        run_phase(8'd128, 8'd1, 4'd8, 128, 50, 1'b0);
        run_phase(8'd200, 8'd3, 4'd15, 160, 60, 1'b0);
        run_phase(8'd1, 8'd128, 4'd1, 128, 50, 1'b0);
        run_phase(8'd128, 8'd128, 4'd1, 120, 60, 1'b0);
        run_phase(8'd255, 8'd255, 4'd15, 40, 20, 1'b0);
        run_phase(8'd24, 8'd10, 4'd4, 120, 80, 1'b1);
        repeat (3)
            run_phase(8'($urandom_range(1, 40)), 8'($urandom_range(1, 16)),
                      4'($urandom_range(0, 15)), 100, 50, 1'b0);
        run_phase(8'd5, 8'd7, 4'd2, 28, 50, 1'b0);

        $display("Covered %0d plane loads and %0d pixel reads (%0d outside the image)",
                 n_loads, n_reads, n_outside);
        $display("over %0d register writes; colour indexes seen: %08b",
                 n_reg_writes, colours_seen);
        if (n_bad == 0 && n_unexpected == 0 && pixel_exp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing pixels",
                     n_bad, n_unexpected, pixel_exp.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
